>>> rtl/bphd_pkg.sv
// Shared types and constants of the button press and hold detector.
// Holds register codes, reset values and the structs passed between the lanes,
// the merge stage and the top level. Depends on nothing.
package bphd_pkg;

	localparam int NBTN   = 8;
	localparam int NPOWER = 4;

	// Configuration register indexes
	typedef enum logic [2:0] {
		CFG_CONFIRM   = 3'd0,
		CFG_CLICK     = 3'd1,
		CFG_LONG      = 3'd2,
		CFG_SHORT_REL = 3'd3,
		CFG_LOCKOUT   = 3'd4
	} cfg_addr_t;

	localparam logic [7:0]  CONFIRM_RST   = 8'd10;
	localparam logic [15:0] CLICK_RST     = 16'd20;
	localparam logic [15:0] LONG_RST      = 16'd3000;
	localparam logic [15:0] SHORT_REL_RST = 16'd500;
	localparam logic [15:0] LOCKOUT_RST   = 16'd1500;

	typedef struct packed {
		logic [7:0]  confirm_ticks;
		logic [15:0] click_ticks;
		logic [15:0] long_ticks;
		logic [15:0] short_release_ticks;
		logic [15:0] lockout_ms;
	} cfg_t;

	// What one button lane found in the current request
	typedef struct packed {
		logic click;
		logic long_hit;
		logic wr;
	} lane_ev_t;

	typedef struct packed {
		logic [NBTN-1:0]   click_fire;
		logic [NPOWER-1:0] long_fire;
		logic              led_write;
		logic              led_value;
	} res_t;

endpackage

>>> rtl/bphd_if.sv
// Valid/ready channel interfaces of the button press and hold detector:
// sample input, result output and configuration write port.
// Depends on nothing.
interface bphd_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  button_levels;
	logic [31:0] now_ms;
	modport source (output valid, button_levels, now_ms, input ready);
	modport sink (input valid, button_levels, now_ms, output ready);
endinterface

interface bphd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] click_fire;
	logic [3:0] long_fire;
	logic       led_write;
	logic       led_value;
	modport source (output valid, click_fire, long_fire, led_write, led_value, input ready);
	modport sink (input valid, click_fire, long_fire, led_write, led_value, output ready);
endinterface

interface bphd_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  addr;
	logic [15:0] data;
	modport source (output valid, addr, data, input ready);
	modport sink (input valid, addr, data, output ready);
endinterface

>>> rtl/bphd_lane.sv
// One button lane: edge confirm countdown, hold counter, click lockout.
// Reports the events of the current request to the merge stage.
// Depends on bphd_pkg.
module bphd_lane (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic            low,
	input  logic            prev_high,
	input  logic [31:0]     now_ms,
	input  bphd_pkg::cfg_t  cfg,
	output bphd_pkg::lane_ev_t ev
);
	import bphd_pkg::*;

	logic [7:0]  cnt_q;
	logic        pressed_q;
	logic [15:0] hold_q;
	logic [31:0] last_q;
	logic        seen_q;

	logic [15:0] hold_inc;
	logic [31:0] since;
	logic        advance;
	logic        click_ok;
	logic        rel;

	// Evaluate hold, click, long and release events
	always_comb begin
		hold_inc = hold_q + 16'd1;
		since    = now_ms - last_q;
		advance  = pressed_q && low && (hold_q != 16'hFFFF);
		rel      = pressed_q && !low;
		click_ok = !seen_q || ((now_ms > last_q) && (since > {16'd0, cfg.lockout_ms}));
		ev.click    = advance && (hold_inc == cfg.click_ticks) && click_ok;
		ev.long_hit = advance && (hold_inc == cfg.long_ticks);
		ev.wr       = ev.click || ev.long_hit ||
		              (rel && (hold_q < cfg.short_release_ticks));
	end

	// Advance press state once per accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			pressed_q <= 1'b0;
			hold_q    <= '0;
			seen_q    <= 1'b0;
		end else if (accept) begin
			if (pressed_q) begin
				if (!low) begin
					pressed_q <= 1'b0;
					hold_q    <= '0;
				end else if (advance) begin
					hold_q <= hold_inc;
				end
			end else if (cnt_q != 8'd0) begin
				cnt_q <= cnt_q - 8'd1;
				if (cnt_q == 8'd1 && low) begin
					pressed_q <= 1'b1;
				end
			end else if (low && prev_high) begin
				if (cfg.confirm_ticks == 8'd0) begin
					pressed_q <= 1'b1;
				end else begin
					cnt_q <= cfg.confirm_ticks;
				end
			end
			if (ev.click) begin
				seen_q <= 1'b1;
			end
		end
	end

	// Hold the time of the last accepted click
	always_ff @(posedge clk) begin
		if (accept && ev.click) begin
			last_q <= now_ms;
		end
	end

`ifndef SYNTHESIS
	a_press_excl_confirm: assert property (@(posedge clk) disable iff (!arst_n)
		pressed_q |-> (cnt_q == 8'd0))
		else $error("lane pressed while confirm countdown runs");
	a_hold_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!pressed_q |-> (hold_q == 16'd0))
		else $error("hold counter nonzero on released lane");
`endif

endmodule

>>> rtl/bphd_merge.sv
// Merge stage: gathers the lane events into one result.
// The LED value comes from the last writing lane in the order 0, 4, 1, 5, 2, 6, 3, 7.
// Depends on bphd_pkg.
module bphd_merge (
	input  bphd_pkg::lane_ev_t ev [bphd_pkg::NBTN],
	output bphd_pkg::res_t     res
);
	import bphd_pkg::*;

	// Collect fire bits and resolve the LED write in interleaved lane order
	always_comb begin
		res = '0;
		for (int m = 0; m < NPOWER; m++) begin
			res.click_fire[m]        = ev[m].click;
			res.click_fire[m+NPOWER] = ev[m+NPOWER].click;
			res.long_fire[m]         = ev[m].long_hit;
			if (ev[m].wr) begin
				res.led_write = 1'b1;
				res.led_value = 1'b1;
			end
			if (ev[m+NPOWER].wr) begin
				res.led_write = 1'b1;
				res.led_value = 1'b0;
			end
		end
	end

endmodule

>>> rtl/button_press_hold_detector_core.sv
// Button press and hold detector, top level: configuration registers,
// eight button lanes, merge stage and result register.
// Depends on bphd_pkg, bphd_if, bphd_lane and bphd_merge.
//
// Takes one sample (eight active-low button levels plus a millisecond time
// stamp) per clock and returns one result per sample, in the next cycle, from a
// result register. All eight button lanes work on the same sample in the same
// cycle, so the rate is one sample per clock; the sample port stalls only
// while a result sits in the register and the sink does not take it. Buttons
// of machines at or above MACHINES (capped at four) have no lane and report
// zero. Configuration writes are taken at any time, ready is always high;
// indexes beyond the register list are ignored.
module button_press_hold_detector_core #(
	parameter int MACHINES = 4
) (
	input logic       clk,
	input logic       arst_n,
	bphd_in_if.sink   sample,
	bphd_out_if.source result,
	bphd_cfg_if.sink  cfg
);
	import bphd_pkg::*;

	localparam int ACTIVE = (MACHINES > NPOWER) ? NPOWER : MACHINES;

	cfg_t       cfg_q;
	logic [7:0] prev_q;
	logic       out_valid_q;
	res_t       res_q;
	res_t       res;
	logic       accept;
	lane_ev_t   ev [NBTN];

	assign cfg.ready    = 1'b1;
	assign sample.ready = !out_valid_q || result.ready;
	assign accept       = sample.valid && sample.ready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.confirm_ticks       <= CONFIRM_RST;
			cfg_q.click_ticks         <= CLICK_RST;
			cfg_q.long_ticks          <= LONG_RST;
			cfg_q.short_release_ticks <= SHORT_REL_RST;
			cfg_q.lockout_ms          <= LOCKOUT_RST;
		end else if (cfg.valid) begin
			unique case (cfg_addr_t'(cfg.addr))
				CFG_CONFIRM:   cfg_q.confirm_ticks       <= cfg.data[7:0];
				CFG_CLICK:     cfg_q.click_ticks         <= cfg.data;
				CFG_LONG:      cfg_q.long_ticks          <= cfg.data;
				CFG_SHORT_REL: cfg_q.short_release_ticks <= cfg.data;
				CFG_LOCKOUT:   cfg_q.lockout_ms          <= cfg.data;
				default: ;
			endcase
		end
	end

	// Instantiate lanes for present machines, tie off the rest
	for (genvar b = 0; b < NBTN; b++) begin : g_lane
		if ((b % NPOWER) < ACTIVE) begin : g_on
			bphd_lane u_lane (
				.clk       (clk),
				.arst_n    (arst_n),
				.accept    (accept),
				.low       (!sample.button_levels[b]),
				.prev_high (prev_q[b]),
				.now_ms    (sample.now_ms),
				.cfg       (cfg_q),
				.ev        (ev[b])
			);
		end else begin : g_off
			assign ev[b] = '0;
		end
	end

	bphd_merge u_merge (
		.ev  (ev),
		.res (res)
	);

	// Track previous levels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '1;
		end else if (accept) begin
			prev_q <= sample.button_levels;
		end
	end

	// Hold result until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.click_fire = res_q.click_fire;
	assign result.long_fire  = res_q.long_fire;
	assign result.led_write  = res_q.led_write;
	assign result.led_value  = res_q.led_value;

`ifndef SYNTHESIS
	a_click_writes_led: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (res_q.click_fire != '0)) |-> res_q.led_write)
		else $error("click fired without LED write");
	a_long_writes_led: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (res_q.long_fire != '0)) |-> res_q.led_write)
		else $error("long press fired without LED write");
	a_value_needs_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.led_value) |-> res_q.led_write)
		else $error("LED value set without LED write");
`endif

endmodule
